// ===== rtl/fodtp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and saturation helpers for the plant model.
// No dependencies.
package fodtp_pkg;

  localparam int DELAY_DEPTH = 256;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_W        = 128;
  localparam int OUT_W       = 96;

  localparam logic signed [35:0] FIFTY_Q16 = 36'sd3276800;

  typedef enum logic [2:0] {
    REG_GAIN     = 3'd0,
    REG_OUTFLOW  = 3'd1,
    REG_STEP_MAX = 3'd2,
    REG_LOAD_MIN = 3'd3,
    REG_LOAD_MAX = 3'd4,
    REG_NOISE    = 3'd5,
    REG_TAPS     = 3'd6,
    REG_INTERVAL = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LS, S_LOAD, S_MUL_K, S_SUM, S_MUL_G, S_PV, S_MUL_N, S_FIN
  } state_e;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647) r = 32'sh7fffffff;
    else if (x < -36'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] q16_sat(input logic [63:0] p);
    logic signed [31:0] r;
    if (p[63:47] == 17'h00000 || p[63:47] == 17'h1ffff) r = p[47:16];
    else if (p[63]) r = 32'sh80000000;
    else r = 32'sh7fffffff;
    return r;
  endfunction

endpackage

// ===== rtl/fodtp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fodtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fodtp_smul.sv =====
`timescale 1ns / 1ps
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on fodtp_pkg.
module fodtp_smul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fodtp_pkg::mul_req_t req_i,
  output logic              busy_o,
  output logic [63:0]       prod_o
);

  logic signed [32:0] acc_q, acc_d;
  logic [31:0]        lo_q, lo_d;
  logic signed [32:0] a_q, a_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic signed [32:0] addend;
  logic signed [32:0] sum;

  always_comb begin
    addend = lo_q[0] ? a_q : 33'sd0;
    sum    = (cnt_q == 5'd31) ? acc_q - addend : acc_q + addend;
    acc_d  = acc_q;
    lo_d   = lo_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      acc_d  = 33'sd0;
      lo_d   = req_i.b;
      a_d    = {req_i.a[31], req_i.a};
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {sum[32], sum[32:1]};
      lo_d  = {sum[0], lo_q[31:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    a_q   <= a_d;
  end

  assign busy_o = busy_q;
  assign prod_o = {acc_q[31:0], lo_q};

endmodule

// ===== rtl/fodtp_umod.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring remainder of a 32-bit value by a 16-bit value.
// No dependencies.
module fodtp_umod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [15:0] rem_o
);

  logic [31:0] dvd_q, dvd_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;

  always_comb begin
    trial  = {rem_q, dvd_q[31]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = 16'd0;
      dsr_d  = divisor_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 16'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[15:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/first_order_dead_time_plant.sv =====
`timescale 1ns / 1ps
// Top level of the first-order-plus-dead-time plant: sequencer and datapath.
// Depends on fodtp_pkg, fodtp_ram, fodtp_smul, fodtp_umod.
//
//   port group   dir  word content
//   s_axis_*     in   one scan input
//   m_axis_*     out  one scan result
//   cfg_*        in   register write, no read-back
//
// One scan runs from accept to the next ready input through four passes of the
// bit-serial multiplier, each followed by a setup state, and the idle state;
// the remainder unit runs beside the first pass.
// After reset, taps older than the number of scans written read as zero.
// A result waits in the output register; a new word is taken meanwhile, and
// the sequencer holds only when the next result is ready and the last is not taken.
module first_order_dead_time_plant #(
  parameter int DELAY_DEPTH = fodtp_pkg::DELAY_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // manipulated_value, time_now, time_last, load_random, noise_random
  input  logic [fodtp_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sensed_value, process_value, load_value
  output logic [fodtp_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [fodtp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fodtp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int CW     = $clog2(DELAY_DEPTH + 1);
  localparam int TapMax = DELAY_DEPTH - 1;

  logic [30:0]        gain_q, step_max_q, noise_q;
  logic signed [31:0] outflow_q, load_min_q, load_max_q;
  logic [7:0]         taps_q;
  logic [15:0]        interval_q;

  fodtp_pkg::state_e  state_q, state_d;
  logic signed [31:0] pv_q, load_q, mv_q;
  logic [15:0]        rn_q;
  logic               upd_pre_q, tap_zero_q, tap_ok_q;
  logic [AW-1:0]      wp_q;
  logic [CW-1:0]      cnt_q;
  logic               out_valid_q;
  logic [95:0]        out_data_q;

  fodtp_pkg::mul_req_t mul_req;
  logic               mul_busy, div_busy, div_start;
  logic [63:0]        prod;
  logic [15:0]        rem;
  logic [31:0]        rdata;

  logic               accept, out_load, ram_we;
  logic [AW-1:0]      tap_eff, raddr;
  logic signed [35:0] step, load_sum, sum36, pv36, sense36;
  logic signed [31:0] load_stepd, load_new, diff, outflow, sum, incr, pv_new, tap_val;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == fodtp_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= 31'd655;
      outflow_q  <= 32'sd0;
      step_max_q <= 31'd0;
      load_min_q <= 32'sd0;
      load_max_q <= 32'sd0;
      noise_q    <= 31'd0;
      taps_q     <= 8'd0;
      interval_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (fodtp_pkg::reg_idx_e'(cfg_idx_i))
        fodtp_pkg::REG_GAIN:     gain_q     <= cfg_data_i[30:0];
        fodtp_pkg::REG_OUTFLOW:  outflow_q  <= cfg_data_i;
        fodtp_pkg::REG_STEP_MAX: step_max_q <= cfg_data_i[30:0];
        fodtp_pkg::REG_LOAD_MIN: load_min_q <= cfg_data_i;
        fodtp_pkg::REG_LOAD_MAX: load_max_q <= cfg_data_i;
        fodtp_pkg::REG_NOISE:    noise_q    <= cfg_data_i[30:0];
        fodtp_pkg::REG_TAPS:     taps_q     <= cfg_data_i[7:0];
        fodtp_pkg::REG_INTERVAL: interval_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(taps_q) > 32'(TapMax)) tap_eff = AW'(TapMax);
    else tap_eff = AW'(taps_q);
    raddr = AW'({1'b0, wp_q} + (AW + 1)'(DELAY_DEPTH) - {1'b0, tap_eff});
    if (wp_q >= tap_eff) raddr = wp_q - tap_eff;
  end

  always_comb begin
    step       = $signed({3'b0, prod[47:15]}) - $signed({5'b0, step_max_q});
    load_sum   = 36'(load_q) + step;
    load_stepd = (upd_pre_q && rem == 16'd0) ? fodtp_pkg::sat36(load_sum) : load_q;
    load_new   = load_stepd;
    if (load_new > load_max_q) load_new = load_max_q;
    if (load_new < load_min_q) load_new = load_min_q;
    diff    = fodtp_pkg::sat36(36'(pv_q) - fodtp_pkg::FIFTY_Q16);
    outflow = fodtp_pkg::q16_sat(prod);
    sum36   = 36'(mv_q) - fodtp_pkg::FIFTY_Q16 + 36'(load_q) - 36'(outflow);
    sum     = fodtp_pkg::sat36(sum36);
    incr    = fodtp_pkg::q16_sat(prod);
    pv36    = 36'(pv_q) + 36'(incr);
    pv_new  = fodtp_pkg::sat36(pv36);
    if (tap_zero_q) tap_val = pv_q;
    else if (tap_ok_q) tap_val = rdata;
    else tap_val = 32'sd0;
    sense36 = 36'(tap_val) + $signed({4'b0, prod[47:16]})
            - $signed({6'b0, noise_q[30:1]});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fodtp_pkg::S_IDLE:   if (accept) state_d = fodtp_pkg::S_MUL_LS;
      fodtp_pkg::S_MUL_LS: if (!mul_busy && !div_busy) state_d = fodtp_pkg::S_LOAD;
      fodtp_pkg::S_LOAD:   state_d = fodtp_pkg::S_MUL_K;
      fodtp_pkg::S_MUL_K:  if (!mul_busy) state_d = fodtp_pkg::S_SUM;
      fodtp_pkg::S_SUM:    state_d = fodtp_pkg::S_MUL_G;
      fodtp_pkg::S_MUL_G:  if (!mul_busy) state_d = fodtp_pkg::S_PV;
      fodtp_pkg::S_PV:     state_d = fodtp_pkg::S_MUL_N;
      fodtp_pkg::S_MUL_N:  if (!mul_busy) state_d = fodtp_pkg::S_FIN;
      fodtp_pkg::S_FIN:    if (!out_valid_q || m_axis_tready) state_d = fodtp_pkg::S_IDLE;
      default:             state_d = fodtp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_req   = '0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      fodtp_pkg::S_IDLE: begin
        mul_req.start = accept;
        mul_req.a     = {1'b0, step_max_q};
        mul_req.b     = {16'd0, s_axis_tdata[111:96]};
        div_start     = accept;
      end
      fodtp_pkg::S_LOAD: begin
        mul_req.start = 1'b1;
        mul_req.a     = outflow_q;
        mul_req.b     = diff;
      end
      fodtp_pkg::S_SUM: begin
        mul_req.start = 1'b1;
        mul_req.a     = {1'b0, gain_q};
        mul_req.b     = sum;
      end
      fodtp_pkg::S_PV: begin
        mul_req.start = 1'b1;
        mul_req.a     = {1'b0, noise_q};
        mul_req.b     = {16'd0, rn_q};
        ram_we        = 1'b1;
      end
      fodtp_pkg::S_FIN: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fodtp_pkg::S_IDLE;
      pv_q        <= 32'sd0;
      load_q      <= 32'sd0;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fodtp_pkg::S_LOAD) load_q <= load_new;
      if (ram_we) begin
        pv_q <= pv_new;
        wp_q <= (wp_q == AW'(TapMax)) ? '0 : wp_q + AW'(1);
        if (cnt_q != CW'(DELAY_DEPTH)) cnt_q <= cnt_q + CW'(1);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mv_q       <= s_axis_tdata[31:0];
      rn_q       <= s_axis_tdata[127:112];
      upd_pre_q  <= (interval_q != 16'd0) && (s_axis_tdata[63:32] != s_axis_tdata[95:64]);
      tap_zero_q <= (tap_eff == '0);
      tap_ok_q   <= (CW'(tap_eff) <= cnt_q);
    end
    if (out_load) out_data_q <= {load_q, pv_q, fodtp_pkg::sat36(sense36)};
  end

  fodtp_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .prod_o (prod)
  );

  fodtp_umod u_umod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[63:32]),
    .divisor_i  (interval_q),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  fodtp_ram #(
    .WIDTH (32),
    .DEPTH (DELAY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (pv_new),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/fodtp_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the plant top level, bound to every instance.
// Depends on fodtp_pkg and first_order_dead_time_plant.
module fodtp_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [fodtp_pkg::OUT_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken again while a scan is in progress");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result posted without returning to idle");

  a_no_result_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result posted right after accept");

endmodule

bind first_order_dead_time_plant fodtp_chk u_fodtp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
